// ===== sv/cptb_pkg.sv =====
package cptb_pkg;

   // Field and register widths fixed by the interface.
   localparam int MODE_W        = 20;
   localparam int MODE_FIELD_W  = 5;
   localparam int MODE_TIMERS   = 4;
   localparam int RELOAD_W      = 16;
   localparam int SEL_W         = 2;
   localparam int COUNT_W       = 16;
   localparam int COUNT_SPAN    = 1 << COUNT_W;
   localparam int RESID_W       = 10;
   localparam int CYCLES_W      = 8;
   localparam int INC_W         = 11;
   localparam int INDEX_W       = 2;
   localparam int MASK_W        = 4;
   localparam int OUT_TIMERS    = 4;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 20;
   localparam int REM_STEP_W    = 4;
   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 80;
   localparam int RSP_FIELDS_W  = 2 * MASK_W + 1 + OUT_TIMERS * COUNT_W;

   // Bit positions inside one timer's mode field.
   localparam int MODE_CASCADE_BIT = 2;
   localparam int MODE_IRQ_EN_BIT  = 3;
   localparam int MODE_ENABLE_BIT  = 4;

   // Prescaler dividers of 64, 256 and 1024 as shift amounts.
   localparam int SHIFT_64   = 6;
   localparam int SHIFT_256  = 8;
   localparam int SHIFT_1024 = 10;

   typedef enum logic [1:0] {
      PRESCALE_1    = 2'd0,
      PRESCALE_64   = 2'd1,
      PRESCALE_256  = 2'd2,
      PRESCALE_1024 = 2'd3
   } prescale_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RELOAD_0  = 3'd0,
      REG_RELOAD_1  = 3'd1,
      REG_RELOAD_2  = 3'd2,
      REG_RELOAD_3  = 3'd3,
      REG_MODES     = 3'd4,
      REG_SOUND_SEL = 3'd5
   } csr_index_type;

   typedef enum logic {
      REQ_ADVANCE = 1'b0,
      REQ_RESTART = 1'b1
   } req_mode_type;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_RESTART = 6'b000010,
      S_TIMER   = 6'b000100,
      S_REM     = 6'b001000,
      S_COMMIT  = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic restart;
      logic eval;
      logic rem_step;
      logic rem_commit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_rem;
      logic out_free;
   } status_type;

   // Mode field of one timer; timers without mode bits read as disabled.
   function automatic logic [MODE_FIELD_W-1:0] mode_field(
      input logic [MODE_W-1:0] modes,
      input logic [2:0]        idx
   );
      logic [MODE_FIELD_W-1:0] f;
      case (idx)
         3'd0:    f = modes[0*MODE_FIELD_W +: MODE_FIELD_W];
         3'd1:    f = modes[1*MODE_FIELD_W +: MODE_FIELD_W];
         3'd2:    f = modes[2*MODE_FIELD_W +: MODE_FIELD_W];
         3'd3:    f = modes[3*MODE_FIELD_W +: MODE_FIELD_W];
         default: f = '0;
      endcase
      return f;
   endfunction

endpackage

// ===== sv/cptb_ctrl.sv =====
module cptb_ctrl #(
   parameter int TIMER_COUNT = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tuser,
   output logic                    req_tready,
   input  cptb_pkg::status_type    status,
   output cptb_pkg::cmd_type       cmd,
   output logic [((TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1)-1:0] timer_idx
);

   localparam int TW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   cptb_pkg::state_type                    state_ff, state_in;
   logic [TW-1:0]                          timer_ff, timer_in;
   logic [cptb_pkg::REM_STEP_W-1:0]        step_ff, step_in;
   logic                                   last_timer;
   logic                                   last_step;

   assign last_timer = (timer_ff == TW'(TIMER_COUNT - 1));
   assign last_step  = (step_ff == cptb_pkg::REM_STEP_W'(cptb_pkg::INC_W - 1));
   assign req_tready = (state_ff == cptb_pkg::S_IDLE);
   assign timer_idx  = timer_ff;

   always_comb begin
      state_in = state_ff;
      timer_in = timer_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         cptb_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               timer_in = '0;
               if (req_tuser == cptb_pkg::REQ_RESTART) begin
                  state_in = cptb_pkg::S_RESTART;
               end else begin
                  state_in = cptb_pkg::S_TIMER;
               end
            end
         end
         cptb_pkg::S_RESTART: begin
            cmd.restart = 1'b1;
            state_in    = cptb_pkg::S_DONE;
         end
         cptb_pkg::S_TIMER: begin
            cmd.eval = 1'b1;
            if (status.need_rem) begin
               step_in  = '0;
               state_in = cptb_pkg::S_REM;
            end else if (last_timer) begin
               state_in = cptb_pkg::S_DONE;
            end else begin
               timer_in = timer_ff + 1'b1;
            end
         end
         cptb_pkg::S_REM: begin
            cmd.rem_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (last_step) begin
               state_in = cptb_pkg::S_COMMIT;
            end
         end
         cptb_pkg::S_COMMIT: begin
            cmd.rem_commit = 1'b1;
            if (last_timer) begin
               state_in = cptb_pkg::S_DONE;
            end else begin
               timer_in = timer_ff + 1'b1;
               state_in = cptb_pkg::S_TIMER;
            end
         end
         cptb_pkg::S_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = cptb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cptb_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cptb_pkg::S_IDLE;
         timer_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         timer_ff <= timer_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== sv/cptb_datapath.sv =====
module cptb_datapath #(
   parameter int TIMER_COUNT      = 4,
   parameter int TICKS_PER_REFILL = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [cptb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cptb_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [cptb_pkg::REQ_TDATA_W-1:0]       req_tdata,
   input  cptb_pkg::cmd_type                      cmd,
   input  logic [((TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1)-1:0] timer_idx,
   output cptb_pkg::status_type                   status,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [cptb_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   localparam int TW  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int TKW = $clog2(TICKS_PER_REFILL);
   localparam int CW  = cptb_pkg::COUNT_W;
   localparam int IW  = cptb_pkg::INC_W;
   localparam int RW  = cptb_pkg::RESID_W;

   // Configuration registers.
   logic [cptb_pkg::RELOAD_W-1:0]  reload_ff [TIMER_COUNT];
   logic [cptb_pkg::MODE_W-1:0]    modes_ff;
   logic [cptb_pkg::SEL_W-1:0]     sel_ff;

   // Timer state.
   logic [CW-1:0]                  counts_ff [TIMER_COUNT];
   logic [RW-1:0]                  resid_ff  [TIMER_COUNT];
   logic [TKW-1:0]                 tick_a_ff;
   logic [TKW-1:0]                 tick_b_ff;

   // Request being processed and per-request accumulators.
   logic [cptb_pkg::INDEX_W-1:0]   index_ff;
   logic [cptb_pkg::CYCLES_W-1:0]  cycles_ff;
   logic                           chain_ff;
   logic [TIMER_COUNT-1:0]         irq_ff;
   logic [TIMER_COUNT-1:0]         ovm_ff;
   logic                           refill_ff;

   // Remainder unit: restoring, one quotient bit per cycle.
   logic [IW-1:0]                  rem_acc_ff;
   logic [IW-1:0]                  rem_div_ff;
   logic [IW-1:0]                  rem_p_ff;
   logic [IW:0]                    rem_shift;
   logic [IW-1:0]                  rem_acc_in;

   // Output register.
   logic                           rsp_valid_ff;
   logic [cptb_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // Evaluation of the addressed timer.
   logic [cptb_pkg::MODE_FIELD_W-1:0] cur_mode;
   logic                           enabled;
   logic                           cascaded;
   logic [CW-1:0]                  cur_count;
   logic [RW-1:0]                  cur_resid;
   logic [CW-1:0]                  cur_reload;
   logic [IW-1:0]                  elapsed;
   logic [IW-1:0]                  scaled_inc;
   logic [RW-1:0]                  next_resid;
   logic [IW-1:0]                  inc;
   logic [CW:0]                    sum;
   logic                           wrap;
   logic [IW-1:0]                  excess;
   logic [CW:0]                    period;
   logic                           need_rem;
   logic [CW-1:0]                  eval_count;

   // Commit of one timer's result.
   logic                           commit;
   logic                           commit_ov;
   logic [CW-1:0]                  commit_count;
   logic                           hit_a;
   logic                           hit_b;
   logic [TKW-1:0]                 tick_a_in;
   logic [TKW-1:0]                 tick_b_in;
   logic                           wrap_a;
   logic                           wrap_b;

   logic [CW-1:0]                  count_out [cptb_pkg::OUT_TIMERS];
   logic [cptb_pkg::RSP_FIELDS_W-1:0] rsp_fields;

   assign cur_mode   = cptb_pkg::mode_field(modes_ff, 3'(timer_idx));
   assign enabled    = cur_mode[cptb_pkg::MODE_ENABLE_BIT];
   assign cascaded   = cur_mode[cptb_pkg::MODE_CASCADE_BIT];
   assign cur_count  = counts_ff[timer_idx];
   assign cur_resid  = resid_ff[timer_idx];
   assign cur_reload = reload_ff[timer_idx];
   assign elapsed    = IW'(cur_resid) + IW'(cycles_ff);

   // Prescalers are powers of two, so the divide is a shift and the residue a mask.
   always_comb begin
      case (cptb_pkg::prescale_type'(cur_mode[1:0]))
         cptb_pkg::PRESCALE_64: begin
            scaled_inc = elapsed >> cptb_pkg::SHIFT_64;
            next_resid = RW'(elapsed[cptb_pkg::SHIFT_64-1:0]);
         end
         cptb_pkg::PRESCALE_256: begin
            scaled_inc = elapsed >> cptb_pkg::SHIFT_256;
            next_resid = RW'(elapsed[cptb_pkg::SHIFT_256-1:0]);
         end
         cptb_pkg::PRESCALE_1024: begin
            scaled_inc = elapsed >> cptb_pkg::SHIFT_1024;
            next_resid = RW'(elapsed[cptb_pkg::SHIFT_1024-1:0]);
         end
         default: begin
            scaled_inc = elapsed;
            next_resid = '0;
         end
      endcase
   end

   assign inc    = cascaded ? IW'(chain_ff) : scaled_inc;
   assign sum    = (CW + 1)'(cur_count) + (CW + 1)'(inc);
   assign wrap   = sum[CW];
   // Counts left over after the first wrap; always below 2^IW.
   assign excess = sum[IW-1:0];
   assign period = (CW + 1)'(cptb_pkg::COUNT_SPAN) - (CW + 1)'(cur_reload);
   assign need_rem = enabled && wrap && ((CW + 1)'(excess) >= period);
   assign eval_count = wrap ? (cur_reload + CW'(excess)) : sum[CW-1:0];

   assign rem_shift  = {rem_acc_ff, rem_div_ff[IW-1]};
   assign rem_acc_in = (rem_shift >= {1'b0, rem_p_ff}) ?
                       IW'(rem_shift - {1'b0, rem_p_ff}) : IW'(rem_shift);

   always_comb begin
      commit       = 1'b0;
      commit_ov    = 1'b0;
      commit_count = eval_count;
      if (cmd.eval && enabled && !need_rem) begin
         commit    = 1'b1;
         commit_ov = wrap;
      end else if (cmd.rem_commit) begin
         commit       = 1'b1;
         commit_ov    = 1'b1;
         commit_count = cur_reload + CW'(rem_acc_ff);
      end
   end

   assign hit_a     = commit && commit_ov && (3'(timer_idx) == 3'(sel_ff[0]));
   assign hit_b     = commit && commit_ov && (3'(timer_idx) == 3'(sel_ff[1]));
   assign tick_a_in = (tick_a_ff == TKW'(TICKS_PER_REFILL - 1)) ? '0 : tick_a_ff + 1'b1;
   assign tick_b_in = (tick_b_ff == TKW'(TICKS_PER_REFILL - 1)) ? '0 : tick_b_ff + 1'b1;
   assign wrap_a    = hit_a && (tick_a_in == '0);
   assign wrap_b    = hit_b && (tick_b_in == '0);

   assign status.need_rem = need_rem;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMER_COUNT; i++) begin
            reload_ff[i] <= '0;
            counts_ff[i] <= '0;
            resid_ff[i]  <= '0;
         end
         modes_ff  <= '0;
         sel_ff    <= '0;
         tick_a_ff <= '0;
         tick_b_ff <= '0;
         chain_ff  <= 1'b0;
         irq_ff    <= '0;
         ovm_ff    <= '0;
         refill_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               cptb_pkg::REG_RELOAD_0, cptb_pkg::REG_RELOAD_1,
               cptb_pkg::REG_RELOAD_2, cptb_pkg::REG_RELOAD_3: begin
                  if (32'(csr_index) < TIMER_COUNT) begin
                     reload_ff[TW'(csr_index)] <= csr_wdata[cptb_pkg::RELOAD_W-1:0];
                  end
               end
               cptb_pkg::REG_MODES: begin
                  modes_ff <= csr_wdata[cptb_pkg::MODE_W-1:0];
               end
               cptb_pkg::REG_SOUND_SEL: begin
                  sel_ff <= csr_wdata[cptb_pkg::SEL_W-1:0];
               end
               default: begin
               end
            endcase
         end

         if (cmd.load) begin
            chain_ff  <= 1'b0;
            irq_ff    <= '0;
            ovm_ff    <= '0;
            refill_ff <= 1'b0;
         end

         if (cmd.restart && (32'(index_ff) < TIMER_COUNT)) begin
            counts_ff[TW'(index_ff)] <= reload_ff[TW'(index_ff)];
            resid_ff[TW'(index_ff)]  <= '0;
         end

         if (cmd.eval) begin
            if (!enabled) begin
               chain_ff <= 1'b0;
            end else if (!cascaded) begin
               resid_ff[timer_idx] <= next_resid;
            end
         end

         if (commit) begin
            counts_ff[timer_idx] <= commit_count;
            chain_ff             <= commit_ov;
            if (commit_ov) begin
               ovm_ff[timer_idx] <= 1'b1;
               if (cur_mode[cptb_pkg::MODE_IRQ_EN_BIT]) begin
                  irq_ff[timer_idx] <= 1'b1;
               end
            end
            if (hit_a) begin
               tick_a_ff <= tick_a_in;
            end
            if (hit_b) begin
               tick_b_ff <= tick_b_in;
            end
            if (wrap_a || wrap_b) begin
               refill_ff <= 1'b1;
            end
         end
      end
   end

   // Request payload and remainder unit registers need no reset.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         index_ff  <= req_tdata[cptb_pkg::INDEX_W-1:0];
         cycles_ff <= req_tdata[cptb_pkg::INDEX_W +: cptb_pkg::CYCLES_W];
      end
      if (cmd.eval && need_rem) begin
         rem_acc_ff <= '0;
         rem_div_ff <= excess;
         rem_p_ff   <= IW'(period);
      end else if (cmd.rem_step) begin
         rem_acc_ff <= rem_acc_in;
         rem_div_ff <= {rem_div_ff[IW-2:0], 1'b0};
      end
   end

   for (genvar j = 0; j < cptb_pkg::OUT_TIMERS; j++) begin : g_count_out
      if (j < TIMER_COUNT) begin : g_present
         assign count_out[j] = counts_ff[j];
      end else begin : g_absent
         assign count_out[j] = '0;
      end
   end

   assign rsp_fields = {count_out[3], count_out[2], count_out[1], count_out[0],
                        refill_ff, cptb_pkg::MASK_W'(ovm_ff), cptb_pkg::MASK_W'(irq_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= cptb_pkg::RSP_TDATA_W'(rsp_fields);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/cascaded_prescaled_timer_bank_unit.sv =====
// Channel    Direction  Handshake               Payload
// req_       in         req_tvalid/req_tready   tuser: mode; tdata: timer_index, cycle_count
// rsp_       out        rsp_tvalid/rsp_tready   tdata: irq_raise .. count_3
// csr_       in         csr_we                  csr_index selects, csr_wdata is written
//
// An advance request passes S_TIMER once for each timer, and a timer that wraps more
// than once also passes the restoring remainder unit (S_REM, then S_COMMIT); the result
// is written in S_DONE, and the next request is accepted once the controller is back in S_IDLE.
// A restart request passes S_RESTART and then S_DONE. Reset is synchronous and clears all
// counters, residues, tick counters, flags and configuration registers, not data registers.
// A stalled result waits in the output register while the next request is worked on.

module cascaded_prescaled_timer_bank_unit #(
   parameter int TIMER_COUNT      = 4,
   parameter int TICKS_PER_REFILL = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [cptb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cptb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, from bit 0: timer_index[1:0], cycle_count[9:2], zero fill.
   input  logic [cptb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: mode (0 advance, 1 restart).
   input  logic                                req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, from bit 0: irq_raise[3:0], overflow_mask[7:4], dma_refill[8],
   // count_0[24:9], count_1[40:25], count_2[56:41], count_3[72:57], zero fill.
   output logic [cptb_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int TW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   // The controller sequences requests and timers; the datapath holds all
   // counters, residues and the result register.
   cptb_pkg::cmd_type     cmd;
   cptb_pkg::status_type  status;
   logic [TW-1:0]         timer_idx;

   cptb_ctrl #(
      .TIMER_COUNT (TIMER_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .timer_idx  (timer_idx)
   );

   cptb_datapath #(
      .TIMER_COUNT      (TIMER_COUNT),
      .TICKS_PER_REFILL (TICKS_PER_REFILL)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .timer_idx  (timer_idx),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/tb_cascaded_prescaled_timer_bank_unit.sv =====
`timescale 1ns / 100ps

module tb_cascaded_prescaled_timer_bank_unit;

   localparam int BANK_TIMERS  = 4;
   localparam int REFILL_TICKS = 16;
   // Random requests after the directed part; the final stretch runs without idling.
   localparam int RANDOM_ITEMS = 830;
   localparam int QUIET_ITEMS  = 120;
   // Longer than the worst advance, so this covers a stray late result.
   localparam int DRAIN_CYCLES = 80;
   // Register indexes that no register answers to; writes there must be dropped.
   localparam logic [cptb_pkg::CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [cptb_pkg::CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   // One result as it sits in rsp_tdata, lowest field last.
   typedef struct packed {
      logic [cptb_pkg::OUT_TIMERS-1:0][cptb_pkg::COUNT_W-1:0] counts;
      logic                                                   refill;
      logic [cptb_pkg::MASK_W-1:0]                            ovf;
      logic [cptb_pkg::MASK_W-1:0]                            irq;
   } snapshot_type;

   // Mirror of the timer bank: registers, counters and residues, plus the results
   // still owed by the block in request order.
   class timer_bank_board;
      logic [cptb_pkg::RELOAD_W-1:0] reload [BANK_TIMERS] = '{default: '0};
      logic [cptb_pkg::MODE_W-1:0]   modes = '0;
      logic [cptb_pkg::SEL_W-1:0]    sound_sel = '0;
      logic [cptb_pkg::COUNT_W-1:0]  counts [BANK_TIMERS] = '{default: '0};
      int unsigned         residue [BANK_TIMERS] = '{default: 0};
      int unsigned         ticks_a = 0;
      int unsigned         ticks_b = 0;
      snapshot_type        awaited[$];
      int unsigned         failures = 0;
      int unsigned         checked = 0;
      int unsigned         overflows = 0;
      int unsigned         irqs = 0;
      int unsigned         refills = 0;

      function void write_reg(logic [cptb_pkg::CSR_INDEX_W-1:0] idx,
                              logic [cptb_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            cptb_pkg::REG_RELOAD_0:  reload[0] = data[cptb_pkg::RELOAD_W-1:0];
            cptb_pkg::REG_RELOAD_1:  reload[1] = data[cptb_pkg::RELOAD_W-1:0];
            cptb_pkg::REG_RELOAD_2:  reload[2] = data[cptb_pkg::RELOAD_W-1:0];
            cptb_pkg::REG_RELOAD_3:  reload[3] = data[cptb_pkg::RELOAD_W-1:0];
            cptb_pkg::REG_MODES:     modes = data[cptb_pkg::MODE_W-1:0];
            cptb_pkg::REG_SOUND_SEL: sound_sel = data[cptb_pkg::SEL_W-1:0];
            default: ;
         endcase
      endfunction

      // Works out the result of one accepted request and queues it.
      function void note_request(logic restart, logic [cptb_pkg::INDEX_W-1:0] idx,
                                 logic [cptb_pkg::CYCLES_W-1:0] cycles);
         snapshot_type                      s;
         logic [cptb_pkg::MODE_FIELD_W-1:0] m;
         int unsigned                       inc, divisor, total;
         bit                                chain, wrapped;
         s = '0;
         if (restart == cptb_pkg::REQ_RESTART) begin
            counts[idx] = reload[idx];
            residue[idx] = 0;
         end else begin
            chain = 1'b0;
            for (int t = 0; t < BANK_TIMERS; t++) begin
               m = modes[t*cptb_pkg::MODE_FIELD_W +: cptb_pkg::MODE_FIELD_W];
               wrapped = 1'b0;
               if (!m[cptb_pkg::MODE_ENABLE_BIT]) begin
                  chain = 1'b0;
                  continue;
               end
               if (m[cptb_pkg::MODE_CASCADE_BIT]) begin
                  inc = chain ? 1 : 0;
               end else begin
                  case (cptb_pkg::prescale_type'(m[1:0]))
                     cptb_pkg::PRESCALE_1:   divisor = 1;
                     cptb_pkg::PRESCALE_64:  divisor = 64;
                     cptb_pkg::PRESCALE_256: divisor = 256;
                     default:                divisor = 1024;
                  endcase
                  total = residue[t] + 32'(cycles);
                  inc = total / divisor;
                  residue[t] = total % divisor;
               end
               for (int n = 0; n < inc; n++) begin
                  counts[t] = counts[t] + 1'b1;
                  if (counts[t] == '0) begin
                     counts[t] = reload[t];
                     wrapped = 1'b1;
                  end
               end
               chain = wrapped;
               if (wrapped) begin
                  s.ovf[t] = 1'b1;
                  if (m[cptb_pkg::MODE_IRQ_EN_BIT])
                     s.irq[t] = 1'b1;
                  if (sound_sel[0] == t) begin
                     ticks_a = (ticks_a + 1) % REFILL_TICKS;
                     if (ticks_a == 0)
                        s.refill = 1'b1;
                  end
                  if (sound_sel[1] == t) begin
                     ticks_b = (ticks_b + 1) % REFILL_TICKS;
                     if (ticks_b == 0)
                        s.refill = 1'b1;
                  end
               end
            end
         end
         for (int j = 0; j < cptb_pkg::OUT_TIMERS; j++)
            s.counts[j] = (j < BANK_TIMERS) ? counts[j] : '0;
         awaited.push_back(s);
      endfunction

      function void compare_field(string field, logic [cptb_pkg::COUNT_W-1:0] want_v,
                                  logic [cptb_pkg::COUNT_W-1:0] got_v);
         if (got_v !== want_v) begin
            failures++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
         end
      endfunction

      function void check_snapshot(logic [cptb_pkg::RSP_TDATA_W-1:0] data);
         snapshot_type want, got;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t: result %h arrived with no request outstanding", $time, data);
            return;
         end
         want = awaited.pop_front();
         got = data[cptb_pkg::RSP_FIELDS_W-1:0];
         checked++;
         overflows += $countones(want.ovf);
         irqs += $countones(want.irq);
         refills += 32'(want.refill);
         compare_field("irq_raise", cptb_pkg::COUNT_W'(want.irq),
                       cptb_pkg::COUNT_W'(got.irq));
         compare_field("overflow_mask", cptb_pkg::COUNT_W'(want.ovf),
                       cptb_pkg::COUNT_W'(got.ovf));
         compare_field("dma_refill", cptb_pkg::COUNT_W'(want.refill),
                       cptb_pkg::COUNT_W'(got.refill));
         for (int j = 0; j < cptb_pkg::OUT_TIMERS; j++)
            compare_field($sformatf("count_%0d", j), want.counts[j], got.counts[j]);
         compare_field("zero fill", '0,
                       cptb_pkg::COUNT_W'(data[cptb_pkg::RSP_TDATA_W-1:cptb_pkg::RSP_FIELDS_W]));
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic [cptb_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [cptb_pkg::CSR_DATA_W-1:0]     csr_wdata;
   logic                                req_tvalid;
   logic                                req_tready;
   // tdata, from bit 0: timer_index[1:0], cycle_count[9:2], zero fill.
   logic [cptb_pkg::REQ_TDATA_W-1:0]    req_tdata;
   // tuser: mode (0 advance, 1 restart).
   logic                                req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   // tdata, from bit 0: irq_raise, overflow_mask, dma_refill, count_0 .. count_3, zero fill.
   logic [cptb_pkg::RSP_TDATA_W-1:0]    rsp_tdata;

   timer_bank_board board = new;

   // Idling control shared by the request driver and the result sink. An odds value
   // of zero turns idling off for the current phase; quiet_tail turns it off for good.
   bit quiet_tail = 1'b0;
   int source_idle_odds = 0;
   int sink_idle_odds = 0;
   int sink_hold = 0;
   int unsigned sent = 0;
   int unsigned restarts = 0;
   int unsigned settings = 0;

   cascaded_prescaled_timer_bank_unit #(
      .TIMER_COUNT      (BANK_TIMERS),
      .TICKS_PER_REFILL (REFILL_TICKS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Builds one timer's five-bit mode field.
   function automatic logic [cptb_pkg::MODE_FIELD_W-1:0] timer_mode(
      cptb_pkg::prescale_type ps, logic cascade, logic irq_en, logic enable);
      logic [cptb_pkg::MODE_FIELD_W-1:0] m;
      m = '0;
      m[1:0] = ps;
      m[cptb_pkg::MODE_CASCADE_BIT] = cascade;
      m[cptb_pkg::MODE_IRQ_EN_BIT] = irq_en;
      m[cptb_pkg::MODE_ENABLE_BIT] = enable;
      return m;
   endfunction

   // Register index of timer t's reload value.
   function automatic logic [cptb_pkg::CSR_INDEX_W-1:0] reload_reg(int t);
      return cptb_pkg::CSR_INDEX_W'(int'(cptb_pkg::REG_RELOAD_0) + t);
   endfunction

   // Register writes are driven from a falling edge and take effect at the next
   // rising edge; the mirror is updated at the same time since the block is idle.
   task automatic write_csr(input logic [cptb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [cptb_pkg::CSR_DATA_W-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      board.write_reg(idx, data);
   endtask

   // Presents one request, optionally after an idle gap, and holds it until the
   // block accepts it. Valid stays high on return so that back-to-back requests
   // stream without a bubble; the caller lowers it when the batch is over.
   task automatic send_request(input logic restart,
                               input logic [cptb_pkg::INDEX_W-1:0] idx,
                               input logic [cptb_pkg::CYCLES_W-1:0] cycles);
      if (!quiet_tail && source_idle_odds > 0 && $urandom_range(1, source_idle_odds) == 1) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = restart;
      req_tdata = '0;
      req_tdata[1:0] = idx;
      req_tdata[9:2] = cycles;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_request(restart, idx, cycles);
      sent++;
      if (restart == cptb_pkg::REQ_RESTART)
         restarts++;
      @(negedge clock);
   endtask

   // Waits until every queued result has come back, which leaves the block idle.
   task automatic drain_results();
      req_tvalid = 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
   endtask

   // Result sink: ready by default, with random stall bursts.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold > 0 && !quiet_tail) begin
            rsp_tready = 1'b0;
            sink_hold--;
         end else begin
            rsp_tready = 1'b1;
            sink_hold = 0;
            if (!quiet_tail && sink_idle_odds > 0 && $urandom_range(1, sink_idle_odds) == 1)
               sink_hold = $urandom_range(1, 17);
         end
      end
   end

   // Every handshake on the result channel is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         board.check_snapshot(rsp_tdata);
   end

   initial begin
      int unsigned                       phase_len;
      int unsigned                       random_sent;
      int unsigned                       variant;
      logic [cptb_pkg::MODE_W-1:0]       modes_word;
      logic [cptb_pkg::CYCLES_W-1:0]     cycles;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tuser = cptb_pkg::REQ_ADVANCE;
      req_tdata = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Straight out of reset every timer is disabled and every reload is zero, so an
      // advance changes nothing and a restart just loads zero.
      send_request(cptb_pkg::REQ_ADVANCE, 2'd3, 8'd255);
      send_request(cptb_pkg::REQ_RESTART, 2'd2, 8'd0);
      drain_results();

      // Timer 0 reloads to 0xFFFF, so every increment wraps and one advance wraps it
      // many times; timers 1 and 3 are cascaded, timer 2 is off and breaks the chain.
      // Upper data bits above each register's width must be dropped, and the two
      // unused indexes must be ignored.
      write_csr(cptb_pkg::REG_RELOAD_0, 20'hFFFFF);
      write_csr(cptb_pkg::REG_RELOAD_1, 20'h0FFFE);
      write_csr(cptb_pkg::REG_RELOAD_2, 20'h00000);
      write_csr(cptb_pkg::REG_RELOAD_3, 20'hFFFFF);
      write_csr(REG_SPARE_LO, 20'hABCDE);
      write_csr(REG_SPARE_HI, 20'h12345);
      write_csr(cptb_pkg::REG_MODES,
                {timer_mode(cptb_pkg::PRESCALE_1, 1'b1, 1'b1, 1'b1),
                 timer_mode(cptb_pkg::PRESCALE_1, 1'b1, 1'b0, 1'b0),
                 timer_mode(cptb_pkg::PRESCALE_1, 1'b1, 1'b1, 1'b1),
                 timer_mode(cptb_pkg::PRESCALE_1, 1'b0, 1'b1, 1'b1)});
      // FIFO A follows timer 0 and FIFO B timer 1.
      write_csr(cptb_pkg::REG_SOUND_SEL, 20'hFFFFE);
      settings++;
      // Restarts ignore the cycle count and also load a disabled timer.
      send_request(cptb_pkg::REQ_RESTART, 2'd0, 8'd255);
      send_request(cptb_pkg::REQ_RESTART, 2'd1, 8'd17);
      send_request(cptb_pkg::REQ_RESTART, 2'd2, 8'd255);
      send_request(cptb_pkg::REQ_RESTART, 2'd3, 8'd0);
      send_request(cptb_pkg::REQ_ADVANCE, 2'd0, 8'd255);
      send_request(cptb_pkg::REQ_ADVANCE, 2'd1, 8'd1);
      send_request(cptb_pkg::REQ_ADVANCE, 2'd2, 8'd0);
      drain_results();

      // A cascade bit on timer 0 leaves it frozen. Timer 1 runs on the 1024 prescaler
      // and builds up a residue just below it.
      write_csr(cptb_pkg::REG_MODES,
                {timer_mode(cptb_pkg::PRESCALE_1, 1'b0, 1'b0, 1'b0),
                 timer_mode(cptb_pkg::PRESCALE_1, 1'b1, 1'b1, 1'b1),
                 timer_mode(cptb_pkg::PRESCALE_1024, 1'b0, 1'b1, 1'b1),
                 timer_mode(cptb_pkg::PRESCALE_1, 1'b1, 1'b1, 1'b1)});
      settings++;
      repeat (4) send_request(cptb_pkg::REQ_ADVANCE, 2'd3, 8'd255);
      drain_results();

      // Switching timer 1 to a smaller prescaler leaves a residue far above it, which
      // must be divided out in one go; timer 2 then counts on its wraps.
      write_csr(cptb_pkg::REG_MODES,
                {timer_mode(cptb_pkg::PRESCALE_1, 1'b0, 1'b0, 1'b0),
                 timer_mode(cptb_pkg::PRESCALE_1, 1'b1, 1'b1, 1'b1),
                 timer_mode(cptb_pkg::PRESCALE_64, 1'b0, 1'b1, 1'b1),
                 timer_mode(cptb_pkg::PRESCALE_1, 1'b1, 1'b1, 1'b1)});
      settings++;
      send_request(cptb_pkg::REQ_ADVANCE, 2'd1, 8'd255);
      send_request(cptb_pkg::REQ_ADVANCE, 2'd0, 8'd200);
      drain_results();

      // Every mode bit set and both FIFOs on timer 0.
      write_csr(cptb_pkg::REG_MODES, 20'hFFFFF);
      write_csr(cptb_pkg::REG_SOUND_SEL, 20'h00000);
      settings++;
      send_request(cptb_pkg::REQ_ADVANCE, 2'd2, 8'd255);
      send_request(cptb_pkg::REQ_RESTART, 2'd3, 8'd128);
      drain_results();

      // Random phases: each one writes every register, then streams a batch of
      // requests. Reloads lean toward the top of the range so that overflows, and
      // with them cascades, interrupts and FIFO refills, come often.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         variant = settings % 8;
         if (variant == 0) begin
            for (int t = 0; t < BANK_TIMERS; t++)
               write_csr(reload_reg(t), 20'hFFFFF);
            write_csr(cptb_pkg::REG_MODES, 20'hFFFFF);
            write_csr(cptb_pkg::REG_SOUND_SEL, 20'hFFFFF);
         end else if (variant == 1) begin
            for (int t = 0; t < BANK_TIMERS; t++)
               write_csr(reload_reg(t), 20'h00000);
            write_csr(cptb_pkg::REG_MODES, 20'h00000);
            write_csr(cptb_pkg::REG_SOUND_SEL, 20'h00000);
         end else begin
            for (int t = 0; t < BANK_TIMERS; t++) begin
               case ($urandom_range(0, 3))
                  0: write_csr(reload_reg(t),
                               {4'($urandom), 16'($urandom_range(16'hFF00, 16'hFFFF))});
                  1: write_csr(reload_reg(t), 20'hFFFFF);
                  2: write_csr(reload_reg(t), cptb_pkg::CSR_DATA_W'($urandom));
                  default: write_csr(reload_reg(t),
                                     {4'($urandom), 16'($urandom_range(16'hFFF0, 16'hFFFF))});
               endcase
            end
            for (int t = 0; t < cptb_pkg::MODE_TIMERS; t++)
               modes_word[t*cptb_pkg::MODE_FIELD_W +: cptb_pkg::MODE_FIELD_W] =
                  timer_mode(cptb_pkg::prescale_type'($urandom_range(0, 3)),
                             $urandom_range(0, 2) == 0,
                             $urandom_range(0, 1) == 1,
                             $urandom_range(0, 6) != 0);
            write_csr(cptb_pkg::REG_MODES, modes_word);
            write_csr(cptb_pkg::REG_SOUND_SEL, cptb_pkg::CSR_DATA_W'($urandom));
         end
         settings++;

         // Idling density changes per phase, including phases with none at all.
         case ($urandom_range(0, 2))
            0: source_idle_odds = 0;
            1: source_idle_odds = 2;
            default: source_idle_odds = 6;
         endcase
         case ($urandom_range(0, 2))
            0: sink_idle_odds = 0;
            1: sink_idle_odds = 2;
            default: sink_idle_odds = 6;
         endcase

         phase_len = $urandom_range(25, 70);
         for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
            quiet_tail = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
            case ($urandom_range(0, 9))
               0: cycles = '0;
               1: cycles = '1;
               default: cycles = cptb_pkg::CYCLES_W'($urandom);
            endcase
            if ($urandom_range(0, 5) == 0)
               send_request(cptb_pkg::REQ_RESTART, cptb_pkg::INDEX_W'($urandom), cycles);
            else
               send_request(cptb_pkg::REQ_ADVANCE, cptb_pkg::INDEX_W'($urandom), cycles);
            random_sent++;
         end
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d requests (%0d restarts) over %0d register settings.",
               sent, restarts, settings);
      $display("Checked %0d results: %0d overflows, %0d interrupts, %0d refill requests.",
               board.checked, board.overflows, board.irqs, board.refills);
      if (board.failures == 0 && board.awaited.size() == 0)
         $display("cascaded_prescaled_timer_bank_unit test passed");
      else
         $display("cascaded_prescaled_timer_bank_unit test failed");
      $finish;
   end

   // A hung handshake ends the run here; a correct run needs well under a tenth of this.
   initial begin
      #10_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, board.awaited.size());
      $display("cascaded_prescaled_timer_bank_unit test failed");
      $finish;
   end

endmodule
